@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the ray caster RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define GDR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray caster implication check failed");

// Condition that must never hold outside reset.
`define GDR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ray caster forbidden condition seen");

`endif

@@ rtl/core/gdr_pkg.sv @@
// Shared constants, types and state codes of the grid ray caster.
`timescale 1ns / 1ps
`default_nettype none
package gdr_pkg;

    localparam int TILE_PIXELS = 64;
    localparam int FRAC_BITS   = 8;
    localparam int MAP_DIM     = 64;

    // One tile in fixed point is a power of two, so cell index is a shift.
    localparam int TILE_SHIFT  = $clog2(TILE_PIXELS) + FRAC_BITS;
    localparam int CELL_BITS   = $clog2(MAP_DIM);
    localparam int ADDR_W      = 2 * CELL_BITS;
    localparam int GRID_DEPTH  = MAP_DIM * MAP_DIM;

    localparam int WALK_CAP    = 2 * MAP_DIM + 4;
    localparam int WALK_CNT_W  = $clog2(WALK_CAP + 1);

    localparam int LEN_W       = 22;
    localparam int POS_W       = 20;
    localparam int DIV_W       = 35;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int DVSR_W      = 15;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 64;
    localparam int SIDE_W      = 40;
    localparam int DELTA_W     = 31;

    // Quarter-wave sine polynomial coefficients, Q14.
    localparam int Q14_ONE     = 16384;
    localparam int SIN_C0      = 25736;
    localparam int SIN_C1      = 10583;
    localparam int SIN_C2      = 1232;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_WALL  = 2'd1;
    localparam logic [1:0] CELL_DOOR  = 2'd2;
    localparam logic [1:0] CELL_RSVD  = 2'd3;

    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIN0,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_SIN4,
        ST_DSTART,
        ST_DWAIT,
        ST_SMUL,
        ST_SSET,
        ST_WSTEP,
        ST_WCHK,
        ST_LEN,
        ST_LWAIT,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_FIN
    } gdr_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        data;
    } gdr_wr_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } gdr_div_req_t;

endpackage
`default_nettype wire

@@ rtl/core/gdr_mul.sv @@
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module gdr_mul
    import gdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MUL_W-1:0]  a,
    input  wire logic [MUL_W-1:0]  b,
    output logic      [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;

    // Product register; the sequencer reads it in the cycle after issuing operands.
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

@@ rtl/core/gdr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by setup and length.
`timescale 1ns / 1ps
`default_nettype none
module gdr_div
    import gdr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gdr_div_req_t     req,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DVSR_W:0]      rem_sh;
    logic                 fit;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    // One shift, compare and subtract step per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        fit       = rem_sh >= {1'b0, dvsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? DVSR_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fit};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/core/gdr_grid.sv @@
// Map cell memory with a clearing pass after reset and a registered read.
`timescale 1ns / 1ps
`default_nettype none
module gdr_grid
    import gdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gdr_wr_t           wr,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [1:0]        rdata,
    output logic                   clr_busy
);

    logic [1:0]        mem [GRID_DEPTH];
    logic [1:0]        rdata_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [1:0]        mem_data;

    // Clear sweep control: one cell per cycle until the last address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == {ADDR_W{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
        mem_we   = clr_busy_reg | wr.we;
        mem_addr = clr_busy_reg ? clr_cnt_reg : wr.addr;
        mem_data = clr_busy_reg ? CELL_EMPTY : wr.data;
    end

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

@@ rtl/core/grid_dda_ray_caster_top.sv @@
// Top level of the grid ray caster: command sequencer around shared units.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, cmd .. heading   | word in
//  out     | out_valid, out_stall, hit_kind ..    | word out
//  cfg     | cfg_we, cfg_index, cfg_data          | write only
//
// A cast walks at most 132 cells; an axis with a zero component skips its setup.
// Cast time is set by the shared divider and the one map read per walked cell.
// After reset a clearing pass over all 4096 cells runs; no word is taken meanwhile.
// A finished result waits in the output register while out_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module grid_dda_ray_caster_top
    import gdr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [6:0]              cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    cmd,
    input  wire logic [CELL_BITS-1:0]    cell_x,
    input  wire logic [CELL_BITS-1:0]    cell_y,
    input  wire logic [1:0]              cell_kind,
    input  wire logic [POS_W-1:0]        player_x,
    input  wire logic [POS_W-1:0]        player_y,
    input  wire logic [15:0]             heading,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   hit_kind,
    output logic                         hit_side,
    output logic signed [7:0]            hit_col,
    output logic signed [7:0]            hit_row,
    output logic [LEN_W-1:0]             ray_length,
    output logic [POS_W-1:0]             end_x,
    output logic [POS_W-1:0]             end_y
);

`include "assert_macros.svh"

    gdr_state_t state_reg, state_next;

    logic [6:0]            mapw_reg, mapw_next, maph_reg, maph_next;
    logic                  cmd_reg, cmd_next;
    logic [POS_W-1:0]      px_reg, px_next, py_reg, py_next;
    logic [15:0]           ang_reg, ang_next;
    logic                  axis_reg, axis_next;
    logic [14:0]           t_reg, t_next, u2_reg, u2_next;
    logic signed [15:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [DELTA_W-1:0]    ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [SIDE_W-1:0]     sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic                  infx_reg, infx_next, infy_reg, infy_next;
    logic signed [7:0]     mx_reg, mx_next, my_reg, my_next;
    logic                  side_reg, side_next;
    logic [1:0]            kind_reg, kind_next;
    logic [WALK_CNT_W-1:0] walk_cnt_reg, walk_cnt_next;
    logic [DIV_W-1:0]      len_reg, len_next;
    logic [31:0]           lo_reg, lo_next;
    logic [POS_W-1:0]      ex_reg, ex_next, ey_reg, ey_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            o_kind_reg, o_kind_next;
    logic                  o_side_reg, o_side_next;
    logic signed [7:0]     o_col_reg, o_col_next, o_row_reg, o_row_next;
    logic [LEN_W-1:0]      o_len_reg, o_len_next;
    logic [POS_W-1:0]      o_ex_reg, o_ex_next, o_ey_reg, o_ey_next;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_p;
    gdr_div_req_t          div_req;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;
    gdr_wr_t               grid_wr;
    logic [ADDR_W-1:0]     grid_raddr;
    logic [1:0]            grid_rdata;
    logic                  clr_busy;

    logic                  in_accept;
    logic [15:0]           ang_sel;
    logic [14:0]           t_c, ph;
    logic [14:0]           s_c;
    logic signed [15:0]    d_sel;
    logic [14:0]           ad_c;
    logic [POS_W-1:0]      pos_sel;
    logic [14:0]           off_c;
    logic                  x_less;
    logic [6:0]            w_c, h_c;
    logic                  oob;
    logic signed [23:0]    num_c;
    logic [49:0]           acc_c;
    logic [35:0]           mag_c;
    logic signed [37:0]    e_c;
    logic [POS_W-1:0]      e_clamp;

    gdr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    gdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    gdr_grid u_grid (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (grid_wr),
        .raddr    (grid_raddr),
        .rdata    (grid_rdata),
        .clr_busy (clr_busy)
    );

    assign in_stall  = clr_busy || (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Map write port: a stored reserved kind becomes empty.
    always_comb
    begin
        grid_wr.we   = in_accept && (cmd == CMD_WRITE);
        grid_wr.addr = {cell_y, cell_x};
        grid_wr.data = (cell_kind == CELL_RSVD) ? CELL_EMPTY : cell_kind;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mapw_reg      <= 7'd64;
            maph_reg      <= 7'd64;
            out_valid_reg <= 1'b0;
            axis_reg      <= 1'b0;
            walk_cnt_reg  <= '0;
            infx_reg      <= 1'b0;
            infy_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mapw_reg      <= mapw_next;
            maph_reg      <= maph_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            walk_cnt_reg  <= walk_cnt_next;
            infx_reg      <= infx_next;
            infy_reg      <= infy_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ang_reg    <= ang_next;
        t_reg      <= t_next;
        u2_reg     <= u2_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ddx_reg    <= ddx_next;
        ddy_reg    <= ddy_next;
        sdx_reg    <= sdx_next;
        sdy_reg    <= sdy_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        side_reg   <= side_next;
        kind_reg   <= kind_next;
        len_reg    <= len_next;
        lo_reg     <= lo_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        o_kind_reg <= o_kind_next;
        o_side_reg <= o_side_next;
        o_col_reg  <= o_col_next;
        o_row_reg  <= o_row_next;
        o_len_reg  <= o_len_next;
        o_ex_reg   <= o_ex_next;
        o_ey_reg   <= o_ey_next;
    end

    // Per-axis operands shared by the sine, setup, walk, length and end point steps.
    always_comb
    begin
        ang_sel = axis_reg ? ang_reg : ang_reg + 16'(Q14_ONE);
        t_c     = ang_sel[14] ? 15'(Q14_ONE) - {1'b0, ang_sel[13:0]}
                              : {1'b0, ang_sel[13:0]};
        ph      = mul_p[28:14];
        s_c     = (ph > 15'(Q14_ONE)) ? 15'(Q14_ONE) : ph;
        d_sel   = axis_reg ? dy_reg : dx_reg;
        ad_c    = d_sel[15] ? 15'(-d_sel) : d_sel[14:0];
        pos_sel = axis_reg ? py_reg : px_reg;
        off_c   = d_sel[15] ? {1'b0, pos_sel[TILE_SHIFT-1:0]}
                            : 15'(Q14_ONE) - {1'b0, pos_sel[TILE_SHIFT-1:0]};
        x_less  = !infx_reg && (infy_reg || (sdx_reg < sdy_reg));
        w_c     = (mapw_reg > 7'(MAP_DIM)) ? 7'(MAP_DIM) : mapw_reg;
        h_c     = (maph_reg > 7'(MAP_DIM)) ? 7'(MAP_DIM) : maph_reg;
        oob     = mx_reg[7] || my_reg[7] || (mx_reg >= $signed({1'b0, w_c}))
                  || (my_reg >= $signed({1'b0, h_c}));
        // Distance from the player to the crossed grid line.
        if (!side_reg)
        begin
            num_c = !dx_reg[15] ? (24'(mx_reg) <<< TILE_SHIFT) - $signed({4'b0, px_reg})
                                : $signed({4'b0, px_reg}) - (24'(mx_reg + 8'sd1) <<< TILE_SHIFT);
        end
        else
        begin
            num_c = !dy_reg[15] ? (24'(my_reg) <<< TILE_SHIFT) - $signed({4'b0, py_reg})
                                : $signed({4'b0, py_reg}) - (24'(my_reg + 8'sd1) <<< TILE_SHIFT);
        end
        if (num_c < 0)
        begin
            num_c = '0;
        end
        // End point: two partial products, truncated toward zero, clamped.
        acc_c   = 50'(lo_reg) + (50'(mul_p[32:0]) << 17);
        mag_c   = acc_c[49:14];
        e_c     = d_sel[15] ? $signed({18'b0, pos_sel}) - $signed({2'b0, mag_c})
                            : $signed({18'b0, pos_sel}) + $signed({2'b0, mag_c});
        if (e_c < 0)
        begin
            e_clamp = '0;
        end
        else if (e_c > $signed(38'({POS_W{1'b1}})))
        begin
            e_clamp = {POS_W{1'b1}};
        end
        else
        begin
            e_clamp = e_c[POS_W-1:0];
        end
    end

    // Sequencer: next state, unit operands and register updates.
    always_comb
    begin
        state_next     = state_reg;
        mapw_next      = mapw_reg;
        maph_next      = maph_reg;
        cmd_next       = cmd_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ang_next       = ang_reg;
        axis_next      = axis_reg;
        t_next         = t_reg;
        u2_next        = u2_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ddx_next       = ddx_reg;
        ddy_next       = ddy_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        infx_next      = infx_reg;
        infy_next      = infy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        kind_next      = kind_reg;
        walk_cnt_next  = walk_cnt_reg;
        len_next       = len_reg;
        lo_next        = lo_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_kind_next    = o_kind_reg;
        o_side_next    = o_side_reg;
        o_col_next     = o_col_reg;
        o_row_next     = o_row_reg;
        o_len_next     = o_len_reg;
        o_ex_next      = o_ex_reg;
        o_ey_next      = o_ey_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(1) << 30;
        div_req.divisor  = ad_c;
        grid_raddr     = {my_reg[CELL_BITS-1:0], mx_reg[CELL_BITS-1:0]};

        // Register writes are taken in any state.
        if (cfg_we && (cfg_index == CFG_MAP_WIDTH))
        begin
            mapw_next = cfg_data;
        end
        if (cfg_we && (cfg_index == CFG_MAP_HEIGHT))
        begin
            maph_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next      = cmd;
                    px_next       = player_x;
                    py_next       = player_y;
                    ang_next      = heading;
                    axis_next     = 1'b0;
                    mx_next       = $signed({2'b00, player_x[POS_W-1:TILE_SHIFT]});
                    my_next       = $signed({2'b00, player_y[POS_W-1:TILE_SHIFT]});
                    side_next     = 1'b0;
                    kind_next     = CELL_EMPTY;
                    walk_cnt_next = '0;
                    state_next    = (cmd == CMD_CAST) ? ST_SIN0 : ST_FIN;
                end
            end
            ST_SIN0:
            begin
                t_next     = t_c;
                mul_a      = MUL_W'(t_c);
                mul_b      = MUL_W'(t_c);
                state_next = ST_SIN1;
            end
            ST_SIN1:
            begin
                u2_next    = ph;
                mul_a      = MUL_W'(ph);
                mul_b      = MUL_W'(SIN_C2);
                state_next = ST_SIN2;
            end
            ST_SIN2:
            begin
                mul_a      = MUL_W'(u2_reg);
                mul_b      = MUL_W'(15'(SIN_C1) - ph);
                state_next = ST_SIN3;
            end
            ST_SIN3:
            begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = MUL_W'(15'(SIN_C0) - ph);
                state_next = ST_SIN4;
            end
            ST_SIN4:
            begin
                if (axis_reg)
                begin
                    dy_next    = ang_sel[15] ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});
                    axis_next  = 1'b0;
                    state_next = ST_DSTART;
                end
                else
                begin
                    dx_next    = ang_sel[15] ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});
                    axis_next  = 1'b1;
                    state_next = ST_SIN0;
                end
            end
            ST_DSTART:
            begin
                if (d_sel == 16'sd0)
                begin
                    // A zero component never steps: its side stays infinite.
                    if (axis_reg)
                    begin
                        ddy_next  = '0;
                        infy_next = 1'b1;
                    end
                    else
                    begin
                        ddx_next  = '0;
                        infx_next = 1'b1;
                    end
                    axis_next  = 1'b1;
                    state_next = axis_reg ? ST_WSTEP : ST_DSTART;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        ddy_next = div_q[DELTA_W-1:0];
                    end
                    else
                    begin
                        ddx_next = div_q[DELTA_W-1:0];
                    end
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL:
            begin
                mul_a      = MUL_W'(off_c);
                mul_b      = MUL_W'(axis_reg ? ddy_reg : ddx_reg);
                state_next = ST_SSET;
            end
            ST_SSET:
            begin
                if (axis_reg)
                begin
                    sdy_next  = mul_p[TILE_SHIFT +: SIDE_W];
                    infy_next = 1'b0;
                end
                else
                begin
                    sdx_next  = mul_p[TILE_SHIFT +: SIDE_W];
                    infx_next = 1'b0;
                end
                axis_next  = 1'b1;
                state_next = axis_reg ? ST_WSTEP : ST_DSTART;
            end
            ST_WSTEP:
            begin
                if (walk_cnt_reg == WALK_CNT_W'(WALK_CAP))
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    if (x_less)
                    begin
                        sdx_next  = sdx_reg + SIDE_W'(ddx_reg);
                        mx_next   = mx_reg + (dx_reg[15] ? -8'sd1 : 8'sd1);
                        side_next = 1'b0;
                    end
                    else
                    begin
                        if (!infy_reg)
                        begin
                            sdy_next = sdy_reg + SIDE_W'(ddy_reg);
                        end
                        my_next   = my_reg + (dy_reg[15] ? -8'sd1 : 8'sd1);
                        side_next = 1'b1;
                    end
                    grid_raddr    = {my_next[CELL_BITS-1:0], mx_next[CELL_BITS-1:0]};
                    walk_cnt_next = walk_cnt_reg + WALK_CNT_W'(1);
                    state_next    = ST_WCHK;
                end
            end
            ST_WCHK:
            begin
                if (oob)
                begin
                    kind_next  = CELL_EMPTY;
                    state_next = ST_LEN;
                end
                else
                begin
                    kind_next  = grid_rdata;
                    state_next = (grid_rdata != CELL_EMPTY) ? ST_LEN : ST_WSTEP;
                end
            end
            ST_LEN:
            begin
                axis_next = side_reg;
                div_req.dividend = {num_c[20:0], {TILE_SHIFT{1'b0}}};
                if (side_reg ? (dy_reg == 16'sd0) : (dx_reg == 16'sd0))
                begin
                    len_next   = '0;
                    axis_next  = 1'b0;
                    state_next = ST_E0;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = side_reg ? (dy_reg[15] ? 15'(-dy_reg) : dy_reg[14:0])
                                               : (dx_reg[15] ? 15'(-dx_reg) : dx_reg[14:0]);
                    state_next      = ST_LWAIT;
                end
            end
            ST_LWAIT:
            begin
                if (div_done)
                begin
                    len_next   = div_q;
                    axis_next  = 1'b0;
                    state_next = ST_E0;
                end
            end
            ST_E0:
            begin
                mul_a      = MUL_W'(ad_c);
                mul_b      = MUL_W'(len_reg[16:0]);
                state_next = ST_E1;
            end
            ST_E1:
            begin
                lo_next    = mul_p[31:0];
                mul_a      = MUL_W'(ad_c);
                mul_b      = MUL_W'(len_reg[DIV_W-1:17]);
                state_next = ST_E2;
            end
            ST_E2:
            begin
                if (axis_reg)
                begin
                    ey_next    = e_clamp;
                    state_next = ST_FIN;
                end
                else
                begin
                    ex_next    = e_clamp;
                    axis_next  = 1'b1;
                    state_next = ST_E0;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg == CMD_CAST)
                    begin
                        o_kind_next = kind_reg;
                        o_side_next = side_reg;
                        o_col_next  = mx_reg;
                        o_row_next  = my_reg;
                        o_len_next  = (len_reg > DIV_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                                        : len_reg[LEN_W-1:0];
                        o_ex_next   = ex_reg;
                        o_ey_next   = ey_reg;
                    end
                    else
                    begin
                        o_kind_next = CELL_EMPTY;
                        o_side_next = 1'b0;
                        o_col_next  = '0;
                        o_row_next  = '0;
                        o_len_next  = '0;
                        o_ex_next   = '0;
                        o_ey_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign hit_kind   = o_kind_reg;
    assign hit_side   = o_side_reg;
    assign hit_col    = o_col_reg;
    assign hit_row    = o_row_reg;
    assign ray_length = o_len_reg;
    assign end_x      = o_ex_reg;
    assign end_y      = o_ey_reg;

    // Divider results arrive only while the sequencer waits for them.
    `GDR_ASSERT_IMPL(a_div_done_waited, div_done, (state_reg == ST_DWAIT) || (state_reg == ST_LWAIT))
    // The walk never runs past its step limit.
    `GDR_ASSERT_NEVER(a_walk_cap, walk_cnt_reg > WALK_CNT_W'(WALK_CAP))
    // At least one axis has a finite side distance during the walk.
    `GDR_ASSERT_IMPL(a_walk_axis, state_reg == ST_WSTEP, !(infx_reg && infy_reg))
    // Nothing runs while the map is being cleared.
    `GDR_ASSERT_IMPL(a_idle_in_clear, clr_busy, state_reg == ST_IDLE)

endmodule
`default_nettype wire

@@ bench/gdr_checker.sv @@
// Checker of the grid ray caster: predicts each result word and compares it.
`timescale 1ns / 1ps
module gdr_checker
    import gdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              cmd,
    input  logic [5:0]        cell_x,
    input  logic [5:0]        cell_y,
    input  logic [1:0]        cell_kind,
    input  logic [19:0]       player_x,
    input  logic [19:0]       player_y,
    input  logic [15:0]       heading,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        hit_kind,
    input  logic              hit_side,
    input  logic signed [7:0] hit_col,
    input  logic signed [7:0] hit_row,
    input  logic [21:0]       ray_length,
    input  logic [19:0]       end_x,
    input  logic [19:0]       end_y,
    output int                fail_count,
    output int                pending
);

    typedef struct {
        logic [1:0]  kind;
        logic        side;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [21:0] len;
        logic [19:0] ex;
        logic [19:0] ey;
    } hit_t;

    localparam longint TILE_FX = longint'(TILE_PIXELS) << FRAC_BITS;
    localparam longint unsigned FAR_SIDE = 64'd1 << 62;

    logic [1:0] grid_model [GRID_DEPTH];
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    hit_t       hit_queue [$];

    assign pending = hit_queue.size();

    // Quarter-wave polynomial sine, Q14.
    function automatic longint sine_q14(logic [15:0] a);
        longint unsigned t, u2, p, s;
        t = a[13:0];
        if (a[14])
            t = 16384 - t;
        u2 = (t * t) >> 14;
        p = 10583 - ((u2 * 1232) >> 14);
        p = 25736 - ((u2 * p) >> 14);
        s = (t * p) >> 14;
        if (s > 16384)
            s = 16384;
        return a[15] ? -longint'(s) : longint'(s);
    endfunction

    // Step direction, per-tile cost and cost to the first grid line of one axis.
    function automatic void axis_init(input longint pos, input longint tile,
                                      input longint d, output longint stp,
                                      output longint unsigned dl,
                                      output longint unsigned sd);
        longint unsigned off;
        stp = (d < 0) ? -1 : 1;
        if (d == 0)
        begin
            dl = 0;
            sd = FAR_SIDE;
            return;
        end
        dl = (64'd1 << 30) / longint'(d < 0 ? -d : d);
        off = (d < 0) ? pos - tile * TILE_FX : (tile + 1) * TILE_FX - pos;
        sd = off * dl / TILE_FX;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Walks the grid along one ray and builds the expected word.
    function automatic hit_t cast_ray(logic [19:0] pxi, logic [19:0] pyi,
                                      logic [15:0] ang);
        hit_t r;
        longint px, py, mx, my, sx, sy, w, h, num, len, dx, dy, dsel;
        longint unsigned ddx, ddy, sdx, sdy;
        logic [1:0] kind;
        logic side;
        px = pxi;
        py = pyi;
        mx = px / TILE_FX;
        my = py / TILE_FX;
        dx = sine_q14(ang + 16'd16384);
        dy = sine_q14(ang);
        axis_init(px, mx, dx, sx, ddx, sdx);
        axis_init(py, my, dy, sy, ddy, sdy);
        w = width_reg > MAP_DIM ? MAP_DIM : width_reg;
        h = height_reg > MAP_DIM ? MAP_DIM : height_reg;
        kind = CELL_EMPTY;
        side = 1'b0;
        for (int n = 0; n < WALK_CAP; n++)
        begin
            if (sdx < sdy)
            begin
                sdx += ddx;
                mx += sx;
                side = 1'b0;
            end
            else
            begin
                sdy += ddy;
                my += sy;
                side = 1'b1;
            end
            if (mx < 0 || mx >= w || my < 0 || my >= h)
                break;
            kind = grid_model[my * MAP_DIM + mx];
            if (kind != CELL_EMPTY)
                break;
        end
        if (side == 1'b0)
        begin
            num = (sx > 0) ? mx * TILE_FX - px : px - (mx + 1) * TILE_FX;
            dsel = dx;
        end
        else
        begin
            num = (sy > 0) ? my * TILE_FX - py : py - (my + 1) * TILE_FX;
            dsel = dy;
        end
        if (num < 0)
            num = 0;
        if (dsel < 0)
            dsel = -dsel;
        len = (dsel != 0) ? (num << 14) / dsel : 0;
        r.kind = kind;
        r.side = side;
        r.col = 8'(clamp(mx, -128, 127));
        r.row = 8'(clamp(my, -128, 127));
        r.len = 22'(len > 4194303 ? 4194303 : len);
        r.ex = 20'(clamp(px + (dx * len) / 16384, 0, 1048575));
        r.ey = 20'(clamp(py + (dy * len) / 16384, 0, 1048575));
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Track registers and map, predict accepted words, compare result words.
    always @(posedge clk or negedge rst_n)
    begin
        hit_t e;
        if (!rst_n)
        begin
            foreach (grid_model[i])
                grid_model[i] = CELL_EMPTY;
            width_reg = 7'd64;
            height_reg = 7'd64;
            fail_count = 0;
            hit_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAP_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == CFG_MAP_HEIGHT)
                    height_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_WRITE)
                begin
                    grid_model[{cell_y, cell_x}] =
                        (cell_kind == CELL_RSVD) ? CELL_EMPTY : cell_kind;
                    e = '{default: '0};
                end
                else
                    e = cast_ray(player_x, player_y, heading);
                hit_queue.push_back(e);
            end
            if (out_valid && !out_stall)
            begin
                if (hit_queue.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = hit_queue.pop_front();
                    check_field("hit_kind", e.kind, hit_kind);
                    check_field("hit_side", e.side, hit_side);
                    check_field("hit_col", $signed(e.col), hit_col);
                    check_field("hit_row", $signed(e.row), hit_row);
                    check_field("ray_length", e.len, ray_length);
                    check_field("end_x", e.ex, end_x);
                    check_field("end_y", e.ey, end_y);
                end
            end
        end
    end

endmodule

@@ bench/tb_grid_dda_ray_caster_top.sv @@
// Testbench top of the grid ray caster: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb_grid_dda_ray_caster_top;
    import gdr_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_MAP_WIDTH;
    logic [6:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = CMD_WRITE;
    logic [5:0] cell_x = '0;
    logic [5:0] cell_y = '0;
    logic [1:0] cell_kind = CELL_EMPTY;
    logic [19:0] player_x = '0;
    logic [19:0] player_y = '0;
    logic [15:0] heading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] hit_kind;
    logic hit_side;
    logic signed [7:0] hit_col;
    logic signed [7:0] hit_row;
    logic [21:0] ray_length;
    logic [19:0] end_x;
    logic [19:0] end_y;
    int fail_count;
    int pending;
    bit jitter = 1'b1;
    int quiet_cycles = 0;
    logic [6:0] cur_w = 7'd64;
    logic [6:0] cur_h = 7'd64;

    always #4 clk = ~clk;

    grid_dda_ray_caster_top dut (.*);

    gdr_checker checker_i (.*);

    // Receiver stalls at random while jitter is on.
    always @(negedge clk)
        out_stall <= jitter && ($urandom_range(0, 99) < 20);

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one word and holds it until it is taken.
    task automatic send_word(logic c, logic [5:0] x, logic [5:0] y, logic [1:0] k,
                             logic [19:0] px, logic [19:0] py, logic [15:0] a);
        @(negedge clk);
        if (jitter && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        cell_x <= x;
        cell_y <= y;
        cell_kind <= k;
        player_x <= px;
        player_y <= py;
        heading <= a;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic put_cell(int x, int y, logic [1:0] k);
        send_word(CMD_WRITE, 6'(x), 6'(y), k, 20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    task automatic cast(logic [19:0] px, logic [19:0] py, logic [15:0] a);
        send_word(CMD_CAST, 6'($urandom), 6'($urandom), 2'($urandom), px, py, a);
    endtask

    // Map size changes only once the block has drained.
    task automatic set_map(logic [6:0] w, logic [6:0] h);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAP_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_MAP_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // Position inside the used part of the map, or anywhere now and then.
    function automatic logic [19:0] pick_pos(logic [6:0] lim);
        int cells;
        cells = (lim == 0) ? 1 : (lim > 64 ? 64 : lim);
        if ($urandom_range(0, 9) == 0)
            return 20'($urandom);
        return 20'($urandom_range(0, cells - 1) * 16384 + $urandom_range(0, 16383));
    endfunction

    initial
    begin
        logic [6:0] widths [8];
        logic [6:0] heights [8];
        widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd12, 7'd37, 7'd8, 7'd64};
        heights = '{7'd64, 7'd1, 7'd0, 7'd100, 7'd9, 7'd5, 7'd64, 7'd20};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: extremes, reserved kind, axis-aligned rays, walls and doors.
        set_map(7'd64, 7'd64);
        put_cell(63, 63, CELL_WALL);
        put_cell(0, 0, CELL_DOOR);
        put_cell(5, 2, CELL_WALL);
        put_cell(2, 5, CELL_DOOR);
        put_cell(0, 0, CELL_RSVD);
        cast(20'd32768 + 20'd100, 20'd32768 + 20'd50, 16'd0);
        cast(20'd32768 + 20'd100, 20'd32768 + 20'd50, 16'd16384);
        cast(20'd32768, 20'd32768, 16'd32768);
        cast(20'd32768, 20'd32768, 16'd49152);
        cast(20'd32768 + 20'd8000, 20'd32768 + 20'd8000, 16'd8192);
        cast(20'd0, 20'd0, 16'd40960);
        cast(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        cast(20'hFFFFF, 20'd0, 16'd24576);
        cast(20'd16384 + 20'd16383, 20'd1, 16'd57344);
        cast(20'd0, 20'hFFFFF, 16'd1);
        put_cell(63, 63, CELL_EMPTY);
        cast(20'd1040000, 20'd1040000, 16'd8192);
        cast(20'd5000, 20'd300000, 16'd0);
        set_map(7'd3, 7'd3);
        cast(20'd200000, 20'd200000, 16'd12345);

        // Random phases: cell writes mixed with casts from inside, with some noise.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_map(widths[ph], heights[ph]);
            jitter = (ph != 6);
            for (int i = 0; i < 62; i++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 30)
                    put_cell($urandom_range(0, (cur_w == 0 || cur_w > 64) ? 63 : cur_w - 1),
                             $urandom_range(0, (cur_h == 0 || cur_h > 64) ? 63 : cur_h - 1),
                             2'($urandom_range(0, 3)));
                else if (r < 38)
                    put_cell($urandom_range(0, 63), $urandom_range(0, 63),
                             2'($urandom_range(0, 3)));
                else
                    cast(pick_pos(cur_w), pick_pos(cur_h), 16'($urandom));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        jitter = 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
